/* sv/pscavg_pkg.sv */
`timescale 1ns / 1ps

package pscavg_pkg;

    // window depth default
    localparam int WINDOW_DEPTH = 5;

    // field widths
    localparam int COUNT_W  = 14;
    localparam int GAIN_W   = 12;
    localparam int OFFSET_W = 24;
    localparam int STEP_W   = 11;
    localparam int PPROD_W  = COUNT_W + GAIN_W;
    localparam int TPROD_W  = STEP_W + GAIN_W;
    localparam int MAG_W    = 26;
    localparam int TEMP_W   = 25;
    localparam int MEAN_W   = 26;
    localparam int BYTE_W   = 8;

    // status bit that marks a bad frame
    localparam int STATUS_ERR_BIT = 6;

    // apb port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // register reset values
    localparam logic [COUNT_W-1:0]  RST_COUNT_FLOOR     = 14'd1638;
    localparam logic [COUNT_W-1:0]  RST_COUNT_CEILING   = 14'd14746;
    localparam logic [GAIN_W-1:0]   RST_PRESSURE_GAIN   = 12'd789;
    localparam logic [OFFSET_W-1:0] RST_PRESSURE_OFFSET = 24'd1292800;
    localparam logic [GAIN_W-1:0]   RST_TEMP_GAIN       = 12'd977;
    localparam logic [OFFSET_W-1:0] RST_TEMP_OFFSET     = 24'd500000;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_COUNT_FLOOR     = 3'd0,
        REG_COUNT_CEILING   = 3'd1,
        REG_PRESSURE_GAIN   = 3'd2,
        REG_PRESSURE_OFFSET = 3'd3,
        REG_TEMP_GAIN       = 3'd4,
        REG_TEMP_OFFSET     = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [COUNT_W-1:0]  count_floor;
        logic [COUNT_W-1:0]  count_ceiling;
        logic [GAIN_W-1:0]   pressure_gain;
        logic [OFFSET_W-1:0] pressure_offset;
        logic [GAIN_W-1:0]   temp_gain;
        logic [OFFSET_W-1:0] temp_offset;
    } t_cfg;

    // per-stage load enables of the pipeline
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } t_pipe_ctl;

endpackage

/* sv/pscavg_regs.sv */
`timescale 1ns / 1ps

module pscavg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pscavg_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [pscavg_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [pscavg_pkg::APB_DATA_W-1:0]  prdata,
    output logic                               pready,
    output pscavg_pkg::t_cfg                   o_cfg
);

    pscavg_pkg::t_cfg r_cfg;
    pscavg_pkg::t_reg_idx idx;
    logic wr_en;

    assign idx    = pscavg_pkg::t_reg_idx'(paddr[pscavg_pkg::APB_ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite & pready;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.count_floor     <= pscavg_pkg::RST_COUNT_FLOOR;
            r_cfg.count_ceiling   <= pscavg_pkg::RST_COUNT_CEILING;
            r_cfg.pressure_gain   <= pscavg_pkg::RST_PRESSURE_GAIN;
            r_cfg.pressure_offset <= pscavg_pkg::RST_PRESSURE_OFFSET;
            r_cfg.temp_gain       <= pscavg_pkg::RST_TEMP_GAIN;
            r_cfg.temp_offset     <= pscavg_pkg::RST_TEMP_OFFSET;
        end else if (wr_en) begin
            case (idx)
                pscavg_pkg::REG_COUNT_FLOOR:
                    r_cfg.count_floor <= pwdata[pscavg_pkg::COUNT_W-1:0];
                pscavg_pkg::REG_COUNT_CEILING:
                    r_cfg.count_ceiling <= pwdata[pscavg_pkg::COUNT_W-1:0];
                pscavg_pkg::REG_PRESSURE_GAIN:
                    r_cfg.pressure_gain <= pwdata[pscavg_pkg::GAIN_W-1:0];
                pscavg_pkg::REG_PRESSURE_OFFSET:
                    r_cfg.pressure_offset <= pwdata[pscavg_pkg::OFFSET_W-1:0];
                pscavg_pkg::REG_TEMP_GAIN:
                    r_cfg.temp_gain <= pwdata[pscavg_pkg::GAIN_W-1:0];
                pscavg_pkg::REG_TEMP_OFFSET:
                    r_cfg.temp_offset <= pwdata[pscavg_pkg::OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            pscavg_pkg::REG_COUNT_FLOOR:
                prdata = pscavg_pkg::APB_DATA_W'(r_cfg.count_floor);
            pscavg_pkg::REG_COUNT_CEILING:
                prdata = pscavg_pkg::APB_DATA_W'(r_cfg.count_ceiling);
            pscavg_pkg::REG_PRESSURE_GAIN:
                prdata = pscavg_pkg::APB_DATA_W'(r_cfg.pressure_gain);
            pscavg_pkg::REG_PRESSURE_OFFSET:
                prdata = pscavg_pkg::APB_DATA_W'(r_cfg.pressure_offset);
            pscavg_pkg::REG_TEMP_GAIN:
                prdata = pscavg_pkg::APB_DATA_W'(r_cfg.temp_gain);
            pscavg_pkg::REG_TEMP_OFFSET:
                prdata = pscavg_pkg::APB_DATA_W'(r_cfg.temp_offset);
            default:
                prdata = '0;
        endcase
    end

endmodule

/* sv/pscavg_convert.sv */
`timescale 1ns / 1ps

module pscavg_convert (
    input  logic                                i_clk,
    input  pscavg_pkg::t_pipe_ctl               i_ctl,
    input  pscavg_pkg::t_cfg                    i_cfg,
    input  logic [pscavg_pkg::BYTE_W-1:0]       i_status_pressure_high,
    input  logic [pscavg_pkg::BYTE_W-1:0]       i_pressure_low,
    input  logic [pscavg_pkg::BYTE_W-1:0]       i_temp_high,
    input  logic [pscavg_pkg::BYTE_W-1:0]       i_temp_low,
    output logic [pscavg_pkg::MAG_W-1:0]        o_mag,
    output logic [pscavg_pkg::TEMP_W-1:0]       o_temp,
    output logic                                o_bad
);

    logic [pscavg_pkg::COUNT_W-1:0] count;
    logic [pscavg_pkg::COUNT_W-1:0] count_lo;
    logic [pscavg_pkg::COUNT_W-1:0] count_clamp;
    logic [pscavg_pkg::STEP_W-1:0]  step;
    logic [pscavg_pkg::MAG_W-1:0]   off_ext;

    // stage 1: clamp and multiply
    logic [pscavg_pkg::PPROD_W-1:0] r_pprod;
    logic [pscavg_pkg::TPROD_W-1:0] r_tprod;
    logic                           r_bad1;

    // stage 2: offset and magnitude
    logic [pscavg_pkg::MAG_W-1:0]   r_mag;
    logic [pscavg_pkg::TEMP_W-1:0]  r_temp;
    logic                           r_bad2;

    assign count = {i_status_pressure_high[5:0], i_pressure_low};
    // floor first, ceiling second: ceiling wins on crossed limits
    assign count_lo    = (count <= i_cfg.count_floor) ? i_cfg.count_floor : count;
    assign count_clamp = (count_lo >= i_cfg.count_ceiling) ? i_cfg.count_ceiling : count_lo;
    // 16-bit word shifted right five
    assign step = {i_temp_high, i_temp_low[7:5]};

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_pprod <= pscavg_pkg::PPROD_W'(count_clamp)
                     * pscavg_pkg::PPROD_W'(i_cfg.pressure_gain);
            r_tprod <= pscavg_pkg::TPROD_W'(step)
                     * pscavg_pkg::TPROD_W'(i_cfg.temp_gain);
            r_bad1  <= i_status_pressure_high[pscavg_pkg::STATUS_ERR_BIT];
        end
    end

    assign off_ext = pscavg_pkg::MAG_W'(i_cfg.pressure_offset);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_mag  <= (pscavg_pkg::MAG_W'(r_pprod) >= off_ext)
                    ? pscavg_pkg::MAG_W'(r_pprod) - off_ext
                    : off_ext - pscavg_pkg::MAG_W'(r_pprod);
            r_temp <= pscavg_pkg::TEMP_W'(r_tprod)
                    - pscavg_pkg::TEMP_W'(i_cfg.temp_offset);
            r_bad2 <= r_bad1;
        end
    end

    assign o_mag  = r_mag;
    assign o_temp = r_temp;
    assign o_bad  = r_bad2;

endmodule

/* sv/pscavg_window.sv */
`timescale 1ns / 1ps

module pscavg_window #(
    parameter int WINDOW_DEPTH = pscavg_pkg::WINDOW_DEPTH
) (
    input  logic                                                       i_clk,
    input  logic                                                       i_rst_n,
    input  pscavg_pkg::t_pipe_ctl                                      i_ctl,
    input  logic [pscavg_pkg::MAG_W-1:0]                               i_mag,
    input  logic [pscavg_pkg::TEMP_W-1:0]                              i_temp,
    input  logic                                                       i_bad,
    output logic [pscavg_pkg::MAG_W+$clog2(WINDOW_DEPTH)-1:0]          o_sum,
    output logic [pscavg_pkg::TEMP_W-1:0]                              o_held,
    output logic                                                       o_bad
);

    localparam int SUM_W  = pscavg_pkg::MAG_W + $clog2(WINDOW_DEPTH);
    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    logic [pscavg_pkg::MAG_W-1:0]  r_ring [WINDOW_DEPTH];
    logic [SLOT_W-1:0]             r_slot;
    logic [SUM_W-1:0]              r_sum;
    logic [pscavg_pkg::TEMP_W-1:0] r_held;
    logic                          r_bad3;

    logic [SLOT_W-1:0] n_slot;
    logic [SUM_W-1:0]  n_sum;
    logic              upd;

    assign upd = i_ctl.ld3 & ~i_bad;

    always_comb begin
        n_slot = (r_slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : r_slot + 1'b1;
        // running sum: drop the overwritten entry, add the new one
        n_sum  = r_sum - SUM_W'(r_ring[r_slot]) + SUM_W'(i_mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW_DEPTH; k++) begin
                r_ring[k] <= '0;
            end
            r_slot <= '0;
            r_sum  <= '0;
            r_held <= '0;
        end else if (upd) begin
            r_ring[r_slot] <= i_mag;
            r_slot         <= n_slot;
            r_sum          <= n_sum;
            r_held         <= i_temp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            r_bad3 <= i_bad;
        end
    end

    assign o_sum  = r_sum;
    assign o_held = r_held;
    assign o_bad  = r_bad3;

endmodule

/* sv/pscavg_divide.sv */
`timescale 1ns / 1ps

module pscavg_divide #(
    parameter int WINDOW_DEPTH = pscavg_pkg::WINDOW_DEPTH
) (
    input  logic                                                i_clk,
    input  pscavg_pkg::t_pipe_ctl                               i_ctl,
    input  logic [pscavg_pkg::MAG_W+$clog2(WINDOW_DEPTH)-1:0]   i_sum,
    input  logic [pscavg_pkg::TEMP_W-1:0]                       i_held,
    input  logic                                                i_bad,
    output logic [pscavg_pkg::MEAN_W-1:0]                       o_mean,
    output logic [pscavg_pkg::TEMP_W-1:0]                       o_temp,
    output logic                                                o_bad
);

    localparam int SUM_W   = pscavg_pkg::MAG_W + $clog2(WINDOW_DEPTH);
    localparam int SHIFT   = SUM_W + $clog2(WINDOW_DEPTH);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    // ceil(2^SHIFT / depth): exact floor quotient for every sum below 2^SUM_W
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    logic [PROD_W-1:0]             r_prod;
    logic [pscavg_pkg::TEMP_W-1:0] r_temp;
    logic                          r_bad;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld4) begin
            r_prod <= PROD_W'(i_sum) * PROD_W'(RECIP);
            r_temp <= i_held;
            r_bad  <= i_bad;
        end
    end

    assign o_mean = r_prod[SHIFT +: pscavg_pkg::MEAN_W];
    assign o_temp = r_temp;
    assign o_bad  = r_bad;

endmodule

/* sv/pressure_sensor_convert_average_top.sv */
`timescale 1ns / 1ps

// Differential-pressure sensor frame converter with a moving average. Each input
// transaction carries the four raw bytes of one sensor frame and yields exactly one
// output transaction: the error flag (status bit 6 of byte 0), the floor mean of the
// last WINDOW_DEPTH good pressure magnitudes (units of 1e-5) and the latest good
// temperature (two's complement, units of 1e-4 degrees). A bad frame leaves the
// window and the held temperature untouched. The block takes one transaction per
// clock while the output side is not stalling; a result is offered once its frame
// has passed the four register stages (convert, offset, window update, reciprocal
// multiply). The window and the held temperature reset to zero; the six calibration
// registers sit on the APB port at byte addresses 0x00 to 0x14 and should only be
// written while the pipeline is empty.
module pressure_sensor_convert_average_top #(
    parameter int WINDOW_DEPTH = pscavg_pkg::WINDOW_DEPTH
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // frame input
    input  logic                                       i_valid,
    output logic                                       o_stall,
    input  logic [pscavg_pkg::BYTE_W-1:0]              i_status_pressure_high,
    input  logic [pscavg_pkg::BYTE_W-1:0]              i_pressure_low,
    input  logic [pscavg_pkg::BYTE_W-1:0]              i_temp_high,
    input  logic [pscavg_pkg::BYTE_W-1:0]              i_temp_low,
    // result output
    output logic                                       o_valid,
    input  logic                                       i_stall,
    output logic                                       o_sensor_error,
    output logic [pscavg_pkg::MEAN_W-1:0]              o_pressure_mean,
    output logic signed [pscavg_pkg::TEMP_W-1:0]       o_temperature_out,
    // configuration
    input  logic                                       psel,
    input  logic                                       penable,
    input  logic                                       pwrite,
    input  logic [pscavg_pkg::APB_ADDR_W-1:0]          paddr,
    input  logic [pscavg_pkg::APB_DATA_W-1:0]          pwdata,
    output logic [pscavg_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                       pready
);

    localparam int SUM_W = pscavg_pkg::MAG_W + $clog2(WINDOW_DEPTH);

    pscavg_pkg::t_cfg      cfg;
    pscavg_pkg::t_pipe_ctl ctl;

    // stage valid bits; stage 4 is the output register
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;

    logic [pscavg_pkg::MAG_W-1:0]  mag;
    logic [pscavg_pkg::TEMP_W-1:0] temp2;
    logic                          bad2;
    logic [SUM_W-1:0]              sum;
    logic [pscavg_pkg::TEMP_W-1:0] held;
    logic                          bad3;
    logic [pscavg_pkg::TEMP_W-1:0] temp_out;

    // a stage loads when it has data upstream and is empty or being drained
    always_comb begin
        ctl.ld4 = r_v3 & (~r_v4 | ~i_stall);
        ctl.ld3 = r_v2 & (~r_v3 | ctl.ld4);
        ctl.ld2 = r_v1 & (~r_v2 | ctl.ld3);
        ctl.ld1 = i_valid & (~r_v1 | ctl.ld2);
    end

    // input side backs up only when stage 1 holds an item that cannot move
    assign o_stall = r_v1 & ~ctl.ld2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= ctl.ld1 | (r_v1 & ~ctl.ld2);
            r_v2 <= ctl.ld2 | (r_v2 & ~ctl.ld3);
            r_v3 <= ctl.ld3 | (r_v3 & ~ctl.ld4);
            r_v4 <= ctl.ld4 | (r_v4 & i_stall);
        end
    end

    // calibration registers
    pscavg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // stages 1 and 2: clamp, scale, offset, magnitude
    pscavg_convert u_convert (
        .i_clk                  (i_clk),
        .i_ctl                  (ctl),
        .i_cfg                  (cfg),
        .i_status_pressure_high (i_status_pressure_high),
        .i_pressure_low         (i_pressure_low),
        .i_temp_high            (i_temp_high),
        .i_temp_low             (i_temp_low),
        .o_mag                  (mag),
        .o_temp                 (temp2),
        .o_bad                  (bad2)
    );

    // stage 3: ring, running sum and held temperature
    pscavg_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_mag   (mag),
        .i_temp  (temp2),
        .i_bad   (bad2),
        .o_sum   (sum),
        .o_held  (held),
        .o_bad   (bad3)
    );

    // stage 4: divide by depth through a reciprocal multiply
    pscavg_divide #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_divide (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_sum   (sum),
        .i_held  (held),
        .i_bad   (bad3),
        .o_mean  (o_pressure_mean),
        .o_temp  (temp_out),
        .o_bad   (o_sensor_error)
    );

    assign o_valid           = r_v4;
    assign o_temperature_out = signed'(temp_out);

endmodule

/* dv/pscavg_frame_checker.sv */
`timescale 1ns / 1ps

module pscavg_frame_checker #(
    parameter int WINDOW_DEPTH = pscavg_pkg::WINDOW_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_frame_valid,
    input  logic                                 i_frame_stall,
    input  logic [pscavg_pkg::BYTE_W-1:0]        i_status_pressure_high,
    input  logic [pscavg_pkg::BYTE_W-1:0]        i_pressure_low,
    input  logic [pscavg_pkg::BYTE_W-1:0]        i_temp_high,
    input  logic [pscavg_pkg::BYTE_W-1:0]        i_temp_low,
    input  logic                                 i_result_valid,
    input  logic                                 i_result_stall,
    input  logic                                 i_sensor_error,
    input  logic [pscavg_pkg::MEAN_W-1:0]        i_pressure_mean,
    input  logic signed [pscavg_pkg::TEMP_W-1:0] i_temperature_out,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pscavg_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [pscavg_pkg::APB_DATA_W-1:0]    pwdata,
    input  logic                                 pready,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    import pscavg_pkg::*;

    localparam int MAX_REPORTS = 10;
    localparam int ENTRY_W     = MAG_W + 1;

    typedef struct packed {
        logic                     sensor_error;
        logic [MEAN_W-1:0]        pressure_mean;
        logic signed [TEMP_W-1:0] temperature;
    } reading_t;

    t_cfg                     cfg;
    logic [ENTRY_W-1:0]       window_mag [WINDOW_DEPTH];
    int                       slot;
    logic signed [TEMP_W-1:0] held_temp;
    reading_t                 readings [$];
    reading_t                 want;
    int                       fail_count;
    int                       reports;

    initial begin
        fail_count = 0;
        reports    = 0;
    end

    function automatic void apply_write(input logic [APB_ADDR_W-1:0] addr,
                                        input logic [APB_DATA_W-1:0] data);
        case (addr[APB_ADDR_W-1:2])
            REG_COUNT_FLOOR:     cfg.count_floor     = data[COUNT_W-1:0];
            REG_COUNT_CEILING:   cfg.count_ceiling   = data[COUNT_W-1:0];
            REG_PRESSURE_GAIN:   cfg.pressure_gain   = data[GAIN_W-1:0];
            REG_PRESSURE_OFFSET: cfg.pressure_offset = data[OFFSET_W-1:0];
            REG_TEMP_GAIN:       cfg.temp_gain       = data[GAIN_W-1:0];
            REG_TEMP_OFFSET:     cfg.temp_offset     = data[OFFSET_W-1:0];
            default: ;
        endcase
    endfunction

    // converts one frame; a good frame updates the window and the held temperature
    function automatic reading_t take_frame(input logic [BYTE_W-1:0] b0, b1, b2, b3);
        reading_t             rd;
        logic [COUNT_W-1:0]   count;
        logic [2*BYTE_W-1:0]  temp_word;
        longint               clamped;
        longint               scaled;
        longint               sum;
        rd.sensor_error = b0[STATUS_ERR_BIT];
        if (!rd.sensor_error) begin
            count     = {b0[COUNT_W-BYTE_W-1:0], b1};
            temp_word = {b2, b3};
            clamped   = longint'(count);
            // floor first, ceiling second: ceiling wins when crossed
            if (clamped <= longint'(cfg.count_floor)) clamped = longint'(cfg.count_floor);
            if (clamped >= longint'(cfg.count_ceiling)) clamped = longint'(cfg.count_ceiling);
            scaled = clamped * longint'(cfg.pressure_gain);
            if (scaled >= longint'(cfg.pressure_offset))
                window_mag[slot] = ENTRY_W'(scaled - longint'(cfg.pressure_offset));
            else
                window_mag[slot] = ENTRY_W'(longint'(cfg.pressure_offset) - scaled);
            slot = (slot == WINDOW_DEPTH - 1) ? 0 : slot + 1;
            held_temp = TEMP_W'(longint'(temp_word[2*BYTE_W-1:2*BYTE_W-STEP_W])
                                * longint'(cfg.temp_gain) - longint'(cfg.temp_offset));
        end
        sum = 0;
        for (int k = 0; k < WINDOW_DEPTH; k++) sum += longint'(window_mag[k]);
        rd.pressure_mean = MEAN_W'(sum / WINDOW_DEPTH);
        rd.temperature   = held_temp;
        return rd;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.count_floor     = RST_COUNT_FLOOR;
            cfg.count_ceiling   = RST_COUNT_CEILING;
            cfg.pressure_gain   = RST_PRESSURE_GAIN;
            cfg.pressure_offset = RST_PRESSURE_OFFSET;
            cfg.temp_gain       = RST_TEMP_GAIN;
            cfg.temp_offset     = RST_TEMP_OFFSET;
            for (int k = 0; k < WINDOW_DEPTH; k++) window_mag[k] = '0;
            slot      = 0;
            held_temp = '0;
            readings.delete();
        end else begin
            if (psel && penable && pwrite && pready) apply_write(paddr, pwdata);
            // result side first: a result never belongs to a frame taken at the same edge
            if (i_result_valid && !i_result_stall) begin
                if (readings.size() == 0) begin
                    fail_count++;
                    if (reports < MAX_REPORTS) begin
                        $display("[%0t] unexpected result: err=%0b mean=%0d temp=%0d",
                                 $time, i_sensor_error, i_pressure_mean, i_temperature_out);
                        reports++;
                    end
                end else begin
                    want = readings.pop_front();
                    if (want.sensor_error !== i_sensor_error ||
                        want.pressure_mean !== i_pressure_mean ||
                        want.temperature !== i_temperature_out) begin
                        fail_count++;
                        if (reports < MAX_REPORTS) begin
                            $display({"[%0t] result differs: exp err=%0b mean=%0d temp=%0d,",
                                      " got err=%0b mean=%0d temp=%0d"},
                                     $time, want.sensor_error, want.pressure_mean,
                                     want.temperature, i_sensor_error, i_pressure_mean,
                                     i_temperature_out);
                            reports++;
                        end
                    end
                end
            end
            if (i_frame_valid && !i_frame_stall)
                readings.push_back(take_frame(i_status_pressure_high, i_pressure_low,
                                              i_temp_high, i_temp_low));
        end
        o_fail_count <= fail_count;
        o_pending    <= readings.size();
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import pscavg_pkg::*;

    localparam int DEPTH            = pscavg_pkg::WINDOW_DEPTH;
    localparam int HOLD_CYCLES      = 150;
    localparam int NUM_PHASES       = 7;
    localparam int RANDOM_PER_PHASE = 100;
    localparam int SETTLE_CYCLES    = 8;
    localparam int CYCLE_LIMIT      = 500000;
    localparam int UNMAPPED_IDX     = REG_TEMP_OFFSET + 1;

    // hand-picked frames {byte0, byte1, byte2, byte3}, run under reset settings
    localparam logic [31:0] DIRECTED_FRAMES [22] = '{
        32'h00_00_00_00,  // count zero, below floor, coldest step
        32'h3F_FF_FF_FF,  // count max, above ceiling, hottest step
        32'h06_66_80_00,  // count right at the floor
        32'h39_9A_7F_E0,  // count right at the ceiling
        32'h06_65_00_1F,  // one below floor, only the dropped temperature bits set
        32'h39_9B_12_34,  // one above ceiling
        32'h40_00_00_00,  // bad frame, status bit 6 only
        32'h80_55_AA_55,  // status bit 7 alone is not an error
        32'hC0_12_34_56,  // both status bits, bad frame
        32'hFF_FF_FF_FF,  // all ones, bad frame
        32'h20_00_40_00,
        32'h06_67_66_A0,  // just past the point where the scaled count crosses the offset
        32'h3F_00_01_00,
        32'h15_55_2A_AA,
        32'h2A_AA_D5_55,
        32'h7F_FF_FF_FF,  // bad frame
        32'hBF_FF_00_00,  // bit 7 set, good frame at max count
        32'h00_01_FF_E0,
        32'h30_00_C0_00,
        32'h0A_BC_DE_F0,
        32'h40_FF_00_00,  // bad frame after the window has wrapped
        32'h11_11_22_22
    };

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic [BYTE_W-1:0]           i_status_pressure_high;
    logic [BYTE_W-1:0]           i_pressure_low;
    logic [BYTE_W-1:0]           i_temp_high;
    logic [BYTE_W-1:0]           i_temp_low;
    logic                        o_valid;
    logic                        i_stall;
    logic                        o_sensor_error;
    logic [MEAN_W-1:0]           o_pressure_mean;
    logic signed [TEMP_W-1:0]    o_temperature_out;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [APB_ADDR_W-1:0]       paddr;
    logic [APB_DATA_W-1:0]       pwdata;
    logic [APB_DATA_W-1:0]       prdata;
    logic                        pready;

    int                          fail_count;
    int                          pending_count;
    int                          cycle_count;
    // no idling on either side while set
    logic                        quiet;
    // asks the result side for one long hold-off
    logic                        hold_req;
    // current clamp limits, used to aim counts near them
    logic [COUNT_W-1:0]          cur_floor;
    logic [COUNT_W-1:0]          cur_ceiling;

    pressure_sensor_convert_average_top #(
        .WINDOW_DEPTH(DEPTH)
    ) uut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_stall                (o_stall),
        .i_status_pressure_high (i_status_pressure_high),
        .i_pressure_low         (i_pressure_low),
        .i_temp_high            (i_temp_high),
        .i_temp_low             (i_temp_low),
        .o_valid                (o_valid),
        .i_stall                (i_stall),
        .o_sensor_error         (o_sensor_error),
        .o_pressure_mean        (o_pressure_mean),
        .o_temperature_out      (o_temperature_out),
        .psel                   (psel),
        .penable                (penable),
        .pwrite                 (pwrite),
        .paddr                  (paddr),
        .pwdata                 (pwdata),
        .prdata                 (prdata),
        .pready                 (pready)
    );

    // watches both channels and the register port, predicts and compares
    pscavg_frame_checker #(
        .WINDOW_DEPTH(DEPTH)
    ) checker_i (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_frame_valid          (i_valid),
        .i_frame_stall          (o_stall),
        .i_status_pressure_high (i_status_pressure_high),
        .i_pressure_low         (i_pressure_low),
        .i_temp_high            (i_temp_high),
        .i_temp_low             (i_temp_low),
        .i_result_valid         (o_valid),
        .i_result_stall         (i_stall),
        .i_sensor_error         (o_sensor_error),
        .i_pressure_mean        (o_pressure_mean),
        .i_temperature_out      (o_temperature_out),
        .psel                   (psel),
        .penable                (penable),
        .pwrite                 (pwrite),
        .paddr                  (paddr),
        .pwdata                 (pwdata),
        .pready                 (pready),
        .o_fail_count           (fail_count),
        .o_pending              (pending_count)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // one register write: setup cycle then access cycle, entered and left at a falling edge
    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // writes all six calibration registers plus one stray write past the map
    task automatic load_settings(input logic [APB_DATA_W-1:0] floor_v, ceiling_v,
                                 input logic [APB_DATA_W-1:0] pgain_v, poffset_v,
                                 input logic [APB_DATA_W-1:0] tgain_v, toffset_v);
        apb_write({REG_COUNT_FLOOR, 2'b00}, floor_v);
        apb_write({REG_COUNT_CEILING, 2'b00}, ceiling_v);
        apb_write({REG_PRESSURE_GAIN, 2'b00}, pgain_v);
        apb_write({REG_PRESSURE_OFFSET, 2'b00}, poffset_v);
        apb_write({REG_TEMP_GAIN, 2'b00}, tgain_v);
        apb_write({REG_TEMP_OFFSET, 2'b00}, toffset_v);
        // index past the list must be ignored
        apb_write(APB_ADDR_W'((UNMAPPED_IDX + $urandom_range(0, 1)) << 2), $urandom);
        cur_floor   = floor_v[COUNT_W-1:0];
        cur_ceiling = ceiling_v[COUNT_W-1:0];
    endtask

    // offers one frame transaction, returns at the falling edge after it is taken
    task automatic send_frame(input logic [BYTE_W-1:0] b0, b1, b2, b3);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid                = 1'b1;
        i_status_pressure_high = b0;
        i_pressure_low         = b1;
        i_temp_high            = b2;
        i_temp_low             = b3;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // random frame: mostly good frames, some aimed at the clamp limits
    task automatic send_random_frame();
        logic [BYTE_W-1:0]  b0;
        logic [BYTE_W-1:0]  b1;
        logic [COUNT_W-1:0] count;
        int                 r;
        r  = $urandom_range(0, 99);
        b0 = BYTE_W'($urandom);
        b1 = BYTE_W'($urandom);
        if (r < 85) b0[STATUS_ERR_BIT] = 1'b0;
        if (r < 12) begin
            count = (r < 6) ? cur_floor : cur_ceiling;
            count = COUNT_W'(count + $urandom_range(0, 2) - 1);
            {b0[COUNT_W-BYTE_W-1:0], b1} = count;
        end
        send_frame(b0, b1, BYTE_W'($urandom), BYTE_W'($urandom));
    endtask

    // wait for every expected result, then let the pipeline empty
    task automatic settle();
        while (pending_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // result side: random stall runs, or one long hold-off on request
    initial begin
        int stall_len;
        int open_len;
        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                i_stall  = 1'b0;
            end else if (quiet) begin
                i_stall = 1'b0;
            end else begin
                stall_len = pick_gap();
                open_len  = $urandom_range(1, 6);
                if (stall_len > 0) begin
                    i_stall = 1'b1;
                    repeat (stall_len) @(negedge i_clk);
                end
                i_stall = 1'b0;
                if (open_len > 1) repeat (open_len - 1) @(negedge i_clk);
            end
        end
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("pressure_sensor_convert_average_top: mismatch");
        $finish;
    end

    // stimulus and verdict
    initial begin
        i_rst_n                = 1'b0;
        i_valid                = 1'b0;
        i_status_pressure_high = '0;
        i_pressure_low         = '0;
        i_temp_high            = '0;
        i_temp_low             = '0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        quiet                  = 1'b0;
        hold_req               = 1'b0;
        cur_floor              = RST_COUNT_FLOOR;
        cur_ceiling            = RST_COUNT_CEILING;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed transactions under the reset calibration
        foreach (DIRECTED_FRAMES[n])
            send_frame(DIRECTED_FRAMES[n][31:24], DIRECTED_FRAMES[n][23:16],
                       DIRECTED_FRAMES[n][15:8], DIRECTED_FRAMES[n][7:0]);
        i_valid = 1'b0;
        settle();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            quiet = (phase == 2) || (phase == 3);
            case (phase)
                // full 32-bit garbage, upper bits must be dropped
                0: load_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                // widest clamp range, top gains, zero offsets
                1: load_settings(0, 'h3FFF, 'hFFF, 0, 'hFFF, 0);
                // crossed limits, zero gains, top offsets: most negative temperature
                2: load_settings('h3FFF, 0, 0, 'hFFFFFF, 0, 'hFFFFFF);
                // ordinary limits, random in-range scaling
                3: load_settings($urandom_range(0, 4000), $urandom_range(12000, 16383),
                                 $urandom_range(0, 4095), $urandom_range(0, 16777215),
                                 $urandom_range(0, 4095), $urandom_range(0, 16777215));
                // floor equal to ceiling
                4: begin
                    cur_floor = COUNT_W'($urandom);
                    load_settings(cur_floor, cur_floor, $urandom_range(0, 4095),
                                  $urandom_range(0, 16777215), $urandom_range(0, 4095),
                                  $urandom_range(0, 16777215));
                end
                // top gains with top offsets
                5: load_settings($urandom_range(0, 16383), 'h3FFF, 'hFFF, 'hFFFFFF,
                                 'hFFF, 'hFFFFFF);
                default: load_settings(RST_COUNT_FLOOR, RST_COUNT_CEILING, RST_PRESSURE_GAIN,
                                       RST_PRESSURE_OFFSET, RST_TEMP_GAIN, RST_TEMP_OFFSET);
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // long hold-off on the result side while frames keep coming back to back
                if (phase == 2 && n == 10) hold_req = 1'b1;
                send_random_frame();
            end
            i_valid = 1'b0;
            settle();
        end

        quiet = 1'b1;
        settle();
        repeat (16) @(posedge i_clk);
        if (fail_count == 0)
            $display("pressure_sensor_convert_average_top: match");
        else
            $display("pressure_sensor_convert_average_top: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
sv/pscavg_pkg.sv
sv/pscavg_regs.sv
sv/pscavg_convert.sv
sv/pscavg_window.sv
sv/pscavg_divide.sv
sv/pressure_sensor_convert_average_top.sv
dv/pscavg_frame_checker.sv
dv/tb_top.sv
